// File: rtl/ordered_array_list_engine_defines.svh
// Assertion macros shared by the ordered array list engine RTL.
`ifndef ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked assertion with an explicit clock and active-low reset.
`define OALE_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same, on the block clock and reset.
`define OALE_ASSERT(lbl, prop, msg) `OALE_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)
`else
`define OALE_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define OALE_ASSERT(lbl, prop, msg)
`endif

`endif

// File: rtl/oale_pkg.sv
// Package with sizes, op and status codes and shared types of the list engine.
package oale_pkg;

    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int OP_W   = 3;
    localparam int POS_W  = 9;
    localparam int WORD_W = 32;
    localparam int LIM_W  = 9;
    localparam int STS_W  = 2;
    localparam int FPOS_W = 8;
    localparam int ECNT_W = 9;

    // common width for count, position and limit compares
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int IN_TDATA_W  = ((POS_W + WORD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((WORD_W + FPOS_W + ECNT_W + 7) / 8) * 8;

    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(256);

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_SET    = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_GET    = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;  // done or found
    localparam logic [STS_W-1:0] STS_RANGE = 2'd1;  // bad position, not found, bad op
    localparam logic [STS_W-1:0] STS_FULL  = 2'd2;  // list full

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] data_word;
    } t_req;

    typedef struct packed {
        logic [STS_W-1:0]         status;
        logic signed [WORD_W-1:0] read_word;
        logic [FPOS_W-1:0]        found_position;
        logic [ECNT_W-1:0]        element_count;
    } t_rsp;

endpackage

// File: rtl/oale_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module oale_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/oale_ctrl.sv
// Request sequencer of the list engine: checks, read-modify-write walks over the store.
`include "ordered_array_list_engine_defines.svh"

module oale_ctrl import oale_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [LIM_W-1:0] i_limit,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output t_rsp             o_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WRW  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]            r_state,  n_state;
    logic [OP_W-1:0]       r_op,     n_op;
    logic [ADDR_W-1:0]     r_pos,    n_pos;
    logic [DATA_WIDTH-1:0] r_word,   n_word;
    logic [CNT_W-1:0]      r_count,  n_count;
    logic [ADDR_W-1:0]     r_ptr,    n_ptr;
    logic [ADDR_W-1:0]     r_last,   n_last;
    logic                  r_issue,  n_issue;
    logic [STS_W-1:0]      r_status, n_status;
    logic [DATA_WIDTH-1:0] r_rdw,    n_rdw;
    logic [ADDR_W-1:0]     r_fpos,   n_fpos;
    logic                  r_rd_vld;
    logic [ADDR_W-1:0]     r_rd_idx;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [CMP_W-1:0]      req_pos_c;
    logic [CMP_W-1:0]      cnt_c;
    logic [CMP_W-1:0]      lim_c;
    logic                  full;
    logic                  pos_gt;
    logic                  pos_ge;
    logic [ADDR_W-1:0]     req_addr;
    logic [DATA_WIDTH-1:0] req_word;
    logic [ADDR_W-1:0]     cnt_addr;
    logic [ADDR_W-1:0]     cnt_m1;

    oale_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    assign req_pos_c = CMP_W'(i_req.position);
    assign cnt_c     = CMP_W'(r_count);
    assign lim_c     = CMP_W'(i_limit);
    assign full      = (cnt_c >= lim_c) || (r_count >= CNT_W'(DEPTH));
    assign pos_gt    = req_pos_c > cnt_c;
    assign pos_ge    = req_pos_c >= cnt_c;
    assign req_addr  = ADDR_W'(i_req.position);
    assign req_word  = DATA_WIDTH'($unsigned(i_req.data_word));
    assign cnt_addr  = ADDR_W'(r_count);
    assign cnt_m1    = ADDR_W'(r_count - 1'b1);

    // one read per cycle while the walk is issuing
    assign ram_re    = (r_state == S_RUN) && r_issue;
    assign ram_raddr = r_ptr;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_pos     = r_pos;
        n_word    = r_word;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_last    = r_last;
        n_issue   = r_issue;
        n_status  = r_status;
        n_rdw     = r_rdw;
        n_fpos    = r_fpos;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_word;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op     = i_req.op;
                    n_pos    = req_addr;
                    n_word   = req_word;
                    n_status = STS_OK;
                    n_rdw    = '0;
                    n_fpos   = '0;
                    n_state  = S_DONE;
                    case (i_req.op)
                        OP_APPEND: begin
                            if (full) begin
                                n_status = STS_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = cnt_addr;
                                ram_wdata = req_word;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        OP_INSERT: begin
                            if (pos_gt) begin
                                n_status = STS_RANGE;
                            end else if (full) begin
                                n_status = STS_FULL;
                            end else if (pos_ge) begin
                                // insert at the tail: nothing to shift
                                ram_we    = 1'b1;
                                ram_waddr = req_addr;
                                ram_wdata = req_word;
                                n_count   = r_count + 1'b1;
                            end else begin
                                // shift up, walking down from the tail
                                n_state = S_RUN;
                                n_issue = 1'b1;
                                n_ptr   = cnt_m1;
                                n_last  = req_addr;
                            end
                        end
                        OP_SET: begin
                            if (pos_ge) begin
                                n_status = STS_RANGE;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = req_addr;
                                ram_wdata = req_word;
                            end
                        end
                        OP_REMOVE: begin
                            if (pos_ge) begin
                                n_status = STS_RANGE;
                            end else begin
                                n_state = S_RUN;
                                n_issue = 1'b1;
                                n_ptr   = req_addr;
                                n_last  = cnt_m1;
                            end
                        end
                        OP_GET: begin
                            if (pos_ge) begin
                                n_status = STS_RANGE;
                            end else begin
                                n_state = S_RUN;
                                n_issue = 1'b1;
                                n_ptr   = req_addr;
                                n_last  = req_addr;
                            end
                        end
                        OP_FIND: begin
                            n_status = STS_RANGE;
                            if (r_count != '0) begin
                                n_state = S_RUN;
                                n_issue = 1'b1;
                                n_ptr   = '0;
                                n_last  = cnt_m1;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_status = STS_RANGE;
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (r_issue) begin
                    if (r_ptr == r_last) begin
                        n_issue = 1'b0;
                    end else if (r_op == OP_INSERT) begin
                        n_ptr = r_ptr - 1'b1;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
                if (r_rd_vld) begin
                    case (r_op)
                        OP_INSERT: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_rd_idx + 1'b1;
                            ram_wdata = ram_rdata;
                            if (r_rd_idx == r_pos) begin
                                n_state = S_WRW;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_rd_idx == r_pos) begin
                                n_rdw = ram_rdata;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_rd_idx - 1'b1;
                                ram_wdata = ram_rdata;
                            end
                            if (r_rd_idx == r_last) begin
                                n_count = r_count - 1'b1;
                                n_state = S_DONE;
                            end
                        end
                        OP_GET: begin
                            n_rdw   = ram_rdata;
                            n_state = S_DONE;
                        end
                        OP_FIND: begin
                            if (ram_rdata == r_word) begin
                                n_status = STS_OK;
                                n_fpos   = r_rd_idx;
                                n_issue  = 1'b0;
                                n_state  = S_DONE;
                            end else if (r_rd_idx == r_last) begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_WRW: begin
                // drop the new word into the gap
                ram_we  = 1'b1;
                n_count = r_count + 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_issue  <= n_issue;
            r_rd_vld <= ram_re;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pos    <= n_pos;
        r_word   <= n_word;
        r_ptr    <= n_ptr;
        r_last   <= n_last;
        r_status <= n_status;
        r_rdw    <= n_rdw;
        r_fpos   <= n_fpos;
        r_rd_idx <= ram_raddr;
    end

    assign o_req_ready           = (r_state == S_IDLE);
    assign o_rsp_valid           = (r_state == S_DONE);
    assign o_rsp.status          = r_status;
    assign o_rsp.read_word       = WORD_W'(r_rdw);
    assign o_rsp.found_position  = FPOS_W'(r_fpos);
    assign o_rsp.element_count   = ECNT_W'(r_count);

    `OALE_ASSERT(a_no_rw_same_addr, (ram_we && ram_re) |-> (ram_waddr != ram_raddr), "read and write hit the same entry")
    `OALE_ASSERT(a_count_step, (r_count != $past(r_count)) |-> ((r_count == $past(r_count) + 1'b1) || (r_count == $past(r_count) - 1'b1) || (r_count == '0)), "count moved by more than one")
    `OALE_ASSERT(a_count_bound, r_count <= CNT_W'(DEPTH), "count above store depth")
    `OALE_ASSERT(a_walk_write_op, (r_state == S_RUN && ram_we) |-> (r_op == OP_INSERT || r_op == OP_REMOVE), "store written during a read-only walk")
    `OALE_ASSERT(a_read_data_in_run, r_rd_vld |-> ($past(r_state) == S_RUN), "read returned without a walk")

endmodule

// File: rtl/ordered_array_list_engine.sv
// Top level of the ordered array list engine: stream ports, limit register, output word register.
//
//  channel   | direction | tdata (low bit up)                      | tuser
//  ----------+-----------+-----------------------------------------+------------
//  s_axis    | in        | position[8:0], data_word[40:9], zeros   | op[2:0]
//  m_axis    | out       | read_word[31:0], found_position[39:32], | status[1:0]
//            |           | element_count[48:40], zeros             |
//  cfg       | in        | i_cfg_wr_data = capacity_limit[8:0]     | -
//
//  A word that reads no store entry (append, set, clear, tail insert, refusals) goes to the
//  done state and then into the output register; get, remove, find and a shifting insert walk
//  the store first (the insert then writes the new word), with store reads at one per cycle
//  through the single read port: 1 for get, count - pos for insert and remove, up to count for
//  find (it stops at the first match). Reset zeroes the element count and sets the limit to
//  256; the store itself is not cleared. The next request word is taken in the cycle after the
//  result enters the output register; a stalled m_axis holds it, and s_axis once a second waits.

module ordered_array_list_engine import oale_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [LIM_W-1:0]       i_cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // position, data_word, zero fill
    input  logic [OP_W-1:0]        s_axis_tuser,   // op
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // read_word, found_position, element_count, fill
    output logic [STS_W-1:0]       m_axis_tuser    // status
);

    logic [LIM_W-1:0] r_limit;
    logic             r_ovld;
    t_rsp             r_orsp;

    t_req             req;
    t_rsp             rsp;
    logic             rsp_valid;
    logic             rsp_ready;

    // unpack the request word
    assign req.op        = s_axis_tuser;
    assign req.position  = s_axis_tdata[POS_W-1:0];
    assign req.data_word = s_axis_tdata[POS_W +: WORD_W];

    oale_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (r_limit),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    // advance the result into the output register when it is empty or being drained
    assign rsp_ready = !r_ovld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_ovld  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (rsp_ready) begin
                r_ovld <= rsp_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_ready && rsp_valid) begin
            r_orsp <= rsp;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tuser  = r_orsp.status;
    assign m_axis_tdata  = OUT_TDATA_W'({r_orsp.element_count, r_orsp.found_position,
                                         r_orsp.read_word});

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the ordered array list engine: stream driver, monitor, predictor.
`timescale 1ns / 100ps

module tb_top;
    import oale_pkg::*;

    // op code 7 is not decoded by the block and must come back as a range error
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 300;   // a full-depth walk plus pipeline slack

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [LIM_W-1:0]       i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // position, data_word, zero fill
    logic [OP_W-1:0]        s_axis_tuser = '0;   // op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // read_word, found_position, element_count
    logic [STS_W-1:0]       m_axis_tuser;        // status

    // request words waiting for the driver, and results still owed by the block
    t_req pending_req_q[$];
    t_rsp list_result_q[$];
    t_req req_on_bus;

    // shadow copy of the list and the limit register
    logic [WORD_W-1:0] list_words [DEPTH];
    int                list_len = 0;
    int                list_limit = 256;

    int sent_count = 0;
    int fail_count = 0;
    int cycle_count = 0;

    ordered_array_list_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Apply one request to the shadow list and return the result the block must produce.
    function automatic t_rsp apply_list_request(t_req rq);
        t_rsp rs;
        int   lim;
        int   cnt;
        int   pos;
        rs  = '0;
        lim = (list_limit > DEPTH) ? DEPTH : list_limit;
        cnt = list_len;
        pos = rq.position;
        case (rq.op)
            OP_APPEND: begin
                if (cnt >= lim) begin
                    rs.status = STS_FULL;
                end else begin
                    list_words[cnt] = rq.data_word;
                    list_len = cnt + 1;
                end
            end
            OP_INSERT: begin
                // the position check wins over the full check
                if (pos > cnt) begin
                    rs.status = STS_RANGE;
                end else if (cnt >= lim) begin
                    rs.status = STS_FULL;
                end else begin
                    for (int i = cnt; i > pos; i--) list_words[i] = list_words[i-1];
                    list_words[pos] = rq.data_word;
                    list_len = cnt + 1;
                end
            end
            OP_SET: begin
                if (pos >= cnt) rs.status = STS_RANGE;
                else list_words[pos] = rq.data_word;
            end
            OP_REMOVE: begin
                if (pos >= cnt) begin
                    rs.status = STS_RANGE;
                end else begin
                    rs.read_word = list_words[pos];
                    for (int i = pos; i + 1 < cnt; i++) list_words[i] = list_words[i+1];
                    list_len = cnt - 1;
                end
            end
            OP_GET: begin
                if (pos >= cnt) rs.status = STS_RANGE;
                else rs.read_word = list_words[pos];
            end
            OP_FIND: begin
                // first match wins; an empty list never matches
                rs.status = STS_RANGE;
                for (int i = 0; i < cnt; i++) begin
                    if (list_words[i] == rq.data_word) begin
                        rs.status = STS_OK;
                        rs.found_position = FPOS_W'(i);
                        break;
                    end
                end
            end
            OP_CLEAR: begin
                list_len = 0;
            end
            default: begin
                rs.status = STS_RANGE;
            end
        endcase
        rs.element_count = ECNT_W'(list_len);
        return rs;
    endfunction

    // Idle percentages: receiver-heavy stalls first, then sender-heavy, then none.
    function automatic int sender_idle_pct();
        if (sent_count < 350) return 36;
        if (sent_count < 700) return 87;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (sent_count < 350) return 87;
        if (sent_count < 700) return 36;
        return 0;
    endfunction

    // Driver: on acceptance predict the result, then present the next word or drop tvalid.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                list_result_q.push_back(apply_list_request(req_on_bus));
                sent_count++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_req_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
                    req_on_bus = pending_req_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_TDATA_W'({req_on_bus.data_word, req_on_bus.position});
                    s_axis_tuser  <= req_on_bus.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status         = m_axis_tuser;
                got.read_word      = m_axis_tdata[WORD_W-1:0];
                got.found_position = m_axis_tdata[WORD_W +: FPOS_W];
                got.element_count  = m_axis_tdata[WORD_W+FPOS_W +: ECNT_W];
                if (list_result_q.size() == 0) begin
                    $error("result word with no request outstanding");
                    fail_count++;
                end else begin
                    want = list_result_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.read_word !== want.read_word) begin
                        $error("read_word: expected %0h, got %0h",
                               want.read_word, got.read_word);
                        fail_count++;
                    end
                    if (got.found_position !== want.found_position) begin
                        $error("found_position: expected %0d, got %0d",
                               want.found_position, got.found_position);
                        fail_count++;
                    end
                    if (got.element_count !== want.element_count) begin
                        $error("element_count: expected %0d, got %0d",
                               want.element_count, got.element_count);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic queue_request(logic [OP_W-1:0] op, int pos, logic [WORD_W-1:0] word);
        t_req rq;
        rq.op        = op;
        rq.position  = POS_W'(pos);
        rq.data_word = word;
        pending_req_q.push_back(rq);
    endtask

    // Hold until every queued word is accepted and every result has come back.
    // Sample on the falling edge, once the driver and monitor have settled.
    task automatic wait_list_idle();
        do @(negedge i_clk);
        while (pending_req_q.size() != 0 || s_axis_tvalid || list_result_q.size() != 0);
    endtask

    // Write the limit register with the block idle.
    task automatic write_capacity(int value);
        wait_list_idle();
        repeat (8) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= LIM_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        list_limit     = value;
    endtask

    // Mostly small values so finds hit duplicates, plus extremes and full random words.
    function automatic logic [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(99);
        if (r < 15) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        if (r < 45) return WORD_W'($urandom_range(15));
        return $urandom;
    endfunction

    // Mostly legal positions against the current length, some edges, some anywhere.
    function automatic int pick_position(logic [OP_W-1:0] op);
        int top;
        int r;
        top = (op == OP_INSERT) ? list_len : list_len - 1;
        r   = $urandom_range(99);
        if (r < 70 && top >= 0) return $urandom_range(top);
        if (r < 82) begin
            case ($urandom_range(2))
                0: return 0;
                1: return list_len;
                default: return (list_len > 0) ? list_len - 1 : 0;
            endcase
        end
        return $urandom_range(511);
    endfunction

    // Feed random requests, keeping only a short backlog so positions track the list.
    task automatic send_random(int n);
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] word;
        int                r;
        for (int k = 0; k < n; k++) begin
            while (pending_req_q.size() >= 2) @(posedge i_clk);
            r = $urandom_range(99);
            if (r < 24)      op = OP_APPEND;
            else if (r < 42) op = OP_INSERT;
            else if (r < 52) op = OP_SET;
            else if (r < 66) op = OP_REMOVE;
            else if (r < 78) op = OP_GET;
            else if (r < 91) op = OP_FIND;
            else if (r < 96) op = OP_CLEAR;
            else             op = OP_UNUSED;
            word = pick_word();
            // search mostly for a word already in the list
            if (op == OP_FIND && list_len > 0 && $urandom_range(99) < 60)
                word = list_words[$urandom_range(list_len - 1)];
            queue_request(op, pick_position(op), word);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass at the reset limit: empty list first, then a short list
        queue_request(OP_CLEAR,  0,   32'h0);
        queue_request(OP_GET,    0,   32'h0);
        queue_request(OP_SET,    0,   32'h1);
        queue_request(OP_REMOVE, 0,   32'h0);
        queue_request(OP_FIND,   0,   32'h0);
        queue_request(OP_INSERT, 1,   32'h2);
        queue_request(OP_INSERT, 0,   32'h7fff_ffff);
        queue_request(OP_APPEND, 0,   32'h8000_0000);
        queue_request(OP_APPEND, 511, 32'h0000_0000);
        queue_request(OP_APPEND, 0,   32'hffff_ffff);
        queue_request(OP_INSERT, 2,   32'h5);
        queue_request(OP_INSERT, 5,   32'h5);
        queue_request(OP_GET,    0,   32'h0);
        queue_request(OP_GET,    5,   32'h0);
        queue_request(OP_GET,    6,   32'h0);
        queue_request(OP_GET,    511, 32'hffff_ffff);
        queue_request(OP_SET,    3,   32'h1234_abcd);
        queue_request(OP_FIND,   0,   32'h5);
        queue_request(OP_FIND,   0,   32'h0bad_0bad);
        queue_request(OP_REMOVE, 2,   32'h0);
        queue_request(OP_REMOVE, 4,   32'h0);
        queue_request(OP_REMOVE, 256, 32'h0);
        queue_request(OP_UNUSED, 3,   32'h0);
        queue_request(OP_INSERT, 511, 32'h0);
        queue_request(OP_CLEAR,  0,   32'h0);

        // small list, lots of full and range cases
        write_capacity(8);
        send_random(200);

        // limit zero: every append and insert is refused
        write_capacity(0);
        send_random(40);

        // limit above depth acts as depth: fill to the top and work on a full list
        write_capacity(511);
        queue_request(OP_CLEAR, 0, 32'h0);
        for (int k = 0; k < DEPTH + 4; k++) begin
            while (pending_req_q.size() >= 2) @(posedge i_clk);
            queue_request(OP_APPEND, $urandom_range(511), pick_word());
        end
        send_random(30);
        // pause the sender until the block has drained, then carry on
        wait_list_idle();
        send_random(30);

        // limits below the current count keep the elements
        write_capacity(1);
        send_random(40);
        write_capacity(2);
        send_random(40);

        write_capacity(16);
        send_random(300);
        write_capacity(256);
        send_random(50);

        wait_list_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (list_result_q.size() != 0) fail_count++;

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/oale_pkg.sv
rtl/oale_ram.sv
rtl/oale_ctrl.sv
rtl/ordered_array_list_engine.sv
tb/tb_top.sv
